FILE: rtl/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg
// Types and constants shared by the text console writer modules.
// ----------------------------------------------------------------------------
package tcw_pkg;

    typedef enum logic [2:0] {
        CMD_PUT       = 3'd0,
        CMD_BACKSPACE = 3'd1,
        CMD_CLEAR     = 3'd2,
        CMD_SET_POS   = 3'd3,
        CMD_READ      = 3'd4
    } cmd_code_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_READ,
        ST_SCROLL,
        ST_FILL,
        ST_DONE
    } state_t;

    localparam logic [7:0] BLANK_CHAR       = 8'h20;
    localparam logic [7:0] NEWLINE_CHAR     = 8'h0A;
    localparam logic [7:0] RESET_COLOR      = 8'h0F;
    localparam logic [7:0] TEXT_COLOR_RESET = 8'h0F;

    localparam int POS_W  = 11;
    localparam int COL_OW = 7;
    localparam int ROW_OW = 5;

    typedef struct packed {
        logic [2:0]  command;
        logic [7:0]  char_code;
        logic        use_own_color;
        logic [7:0]  own_color;
        logic [6:0]  new_column;
        logic [4:0]  new_row;
        logic [10:0] cell_index;
    } cmd_t;

    typedef struct packed {
        logic [10:0] cursor_position;
        logic [6:0]  cursor_column;
        logic [4:0]  cursor_row;
        logic        echo_valid;
        logic [7:0]  echo_char;
        logic [15:0] read_data;
    } rsp_t;

endpackage

FILE: rtl/tcw_if.sv
// ----------------------------------------------------------------------------
// tcw_if
// Valid/ready channels for console commands and their results.
// ----------------------------------------------------------------------------
interface tcw_cmd_if;
    logic        valid;
    logic        ready;
    logic [2:0]  command;
    logic [7:0]  char_code;
    logic        use_own_color;
    logic [7:0]  own_color;
    logic [6:0]  new_column;
    logic [4:0]  new_row;
    logic [10:0] cell_index;

    modport source (
        output valid, command, char_code, use_own_color, own_color,
               new_column, new_row, cell_index,
        input  ready
    );
    modport sink (
        input  valid, command, char_code, use_own_color, own_color,
               new_column, new_row, cell_index,
        output ready
    );
endinterface

interface tcw_rsp_if;
    logic        valid;
    logic        ready;
    logic [10:0] cursor_position;
    logic [6:0]  cursor_column;
    logic [4:0]  cursor_row;
    logic        echo_valid;
    logic [7:0]  echo_char;
    logic [15:0] read_data;

    modport source (
        output valid, cursor_position, cursor_column, cursor_row,
               echo_valid, echo_char, read_data,
        input  ready
    );
    modport sink (
        input  valid, cursor_position, cursor_column, cursor_row,
               echo_valid, echo_char, read_data,
        output ready
    );
endinterface

FILE: rtl/tcw_screen_ram.sv
// ----------------------------------------------------------------------------
// tcw_screen_ram
// Screen cell memory: one write port and one registered read port.
// ----------------------------------------------------------------------------
module tcw_screen_ram #(
    parameter int DEPTH = 2000,
    parameter int AW    = 11
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [15:0]   wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [15:0]   rd_data
);
    logic [15:0] mem [DEPTH];
    logic [15:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
endmodule

FILE: rtl/tcw_ctrl.sv
// ----------------------------------------------------------------------------
// tcw_ctrl
// Command sequencer: cursor state, one sweep address counter that drives the
// reset sweep, clearing, scrolling and fills, and the result fields of each command.
// ----------------------------------------------------------------------------
module tcw_ctrl #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_wr_en,
    input  logic [7:0]                             cfg_wr_data,
    input  logic                                   cmd_valid,
    output logic                                   cmd_ready,
    input  tcw_pkg::cmd_t                          cmd_data,
    output logic                                   res_valid,
    input  logic                                   res_ready,
    output tcw_pkg::rsp_t                          res_data,
    output logic                                   wr_en,
    output logic [$clog2(COLUMNS*ROWS)-1:0]        wr_addr,
    output logic [15:0]                            wr_data,
    output logic                                   rd_en,
    output logic [$clog2(COLUMNS*ROWS)-1:0]        rd_addr,
    input  logic [15:0]                            rd_data
);
    import tcw_pkg::*;

    localparam int CELLS      = COLUMNS * ROWS;
    localparam int SCROLL_CNT = COLUMNS * (ROWS - 1);
    localparam int CELL_AW    = $clog2(CELLS);
    localparam int COL_W      = $clog2(COLUMNS);
    localparam int ROW_W      = $clog2(ROWS);

    localparam logic [CELL_AW-1:0] LAST_CELL  = CELL_AW'(CELLS - 1);
    localparam logic [CELL_AW-1:0] LAST_COPY  = CELL_AW'(SCROLL_CNT - 1);
    localparam logic [CELL_AW-1:0] FILL_START = CELL_AW'(SCROLL_CNT);
    localparam logic [CELL_AW-1:0] ROW_STEP   = CELL_AW'(COLUMNS);
    localparam logic [COL_W-1:0]   LAST_COL   = COL_W'(COLUMNS - 1);
    localparam logic [ROW_W-1:0]   LAST_ROW   = ROW_W'(ROWS - 1);

    state_t               state_reg, state_next;
    logic [CELL_AW-1:0]   sweep_reg, sweep_next;
    logic [COL_W-1:0]     col_reg, col_next;
    logic [ROW_W-1:0]     row_reg, row_next;
    logic [7:0]           fill_color_reg, fill_color_next;
    logic [7:0]           text_color_reg;
    logic                 copy_pend_reg, copy_pend_next;
    logic [CELL_AW-1:0]   copy_addr_reg, copy_addr_next;
    logic                 echo_valid_reg, echo_valid_next;
    logic [7:0]           echo_char_reg, echo_char_next;
    logic [15:0]          read_data_reg, read_data_next;

    logic [CELL_AW-1:0]        cur_addr;
    logic [7:0]                color;
    logic [CELL_AW+POS_W-1:0]  pos_ext;
    logic [COL_W+COL_OW-1:0]   col_ext;
    logic [ROW_W+ROW_OW-1:0]   row_ext;

    assign cur_addr = CELL_AW'(32'(row_reg) * COLUMNS + 32'(col_reg));
    assign color    = cmd_data.use_own_color ? cmd_data.own_color : text_color_reg;
    assign pos_ext  = (CELL_AW + POS_W)'(cur_addr);
    assign col_ext  = (COL_W + COL_OW)'(col_reg);
    assign row_ext  = (ROW_W + ROW_OW)'(row_reg);

    always_comb
    begin
        res_data.cursor_position = pos_ext[POS_W-1:0];
        res_data.cursor_column   = col_ext[COL_OW-1:0];
        res_data.cursor_row      = row_ext[ROW_OW-1:0];
        res_data.echo_valid      = echo_valid_reg;
        res_data.echo_char       = echo_char_reg;
        res_data.read_data       = read_data_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_INIT;
            sweep_reg      <= '0;
            col_reg        <= '0;
            row_reg        <= '0;
            text_color_reg <= TEXT_COLOR_RESET;
            copy_pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sweep_reg     <= sweep_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            copy_pend_reg <= copy_pend_next;
            if (cfg_wr_en)
            begin
                text_color_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        fill_color_reg <= fill_color_next;
        copy_addr_reg  <= copy_addr_next;
        echo_valid_reg <= echo_valid_next;
        echo_char_reg  <= echo_char_next;
        read_data_reg  <= read_data_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        sweep_next      = sweep_reg;
        col_next        = col_reg;
        row_next        = row_reg;
        fill_color_next = fill_color_reg;
        copy_pend_next  = 1'b0;
        copy_addr_next  = copy_addr_reg;
        echo_valid_next = echo_valid_reg;
        echo_char_next  = echo_char_reg;
        read_data_next  = read_data_reg;
        cmd_ready       = 1'b0;
        res_valid       = 1'b0;
        rd_en           = 1'b0;
        rd_addr         = sweep_reg + ROW_STEP;

        // A cell copied during a scroll is written in the cycle after its read.
        wr_en   = copy_pend_reg;
        wr_addr = copy_addr_reg;
        wr_data = rd_data;

        unique case (state_reg)
            ST_INIT:
            begin
                wr_en   = 1'b1;
                wr_addr = sweep_reg;
                wr_data = {RESET_COLOR, BLANK_CHAR};
                if (sweep_reg == LAST_CELL)
                begin
                    sweep_next = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    sweep_next = sweep_reg + CELL_AW'(1);
                end
            end

            ST_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                begin
                    echo_valid_next = 1'b0;
                    echo_char_next  = '0;
                    read_data_next  = '0;
                    state_next      = ST_DONE;
                    unique case (cmd_data.command)
                        CMD_PUT:
                        begin
                            echo_valid_next = 1'b1;
                            echo_char_next  = cmd_data.char_code;
                            if (cmd_data.char_code != NEWLINE_CHAR)
                            begin
                                wr_en   = 1'b1;
                                wr_addr = cur_addr;
                                wr_data = {color, cmd_data.char_code};
                            end
                            if (cmd_data.char_code == NEWLINE_CHAR || col_reg == LAST_COL)
                            begin
                                col_next = '0;
                                if (row_reg == LAST_ROW)
                                begin
                                    sweep_next      = '0;
                                    fill_color_next = color;
                                    state_next      = ST_SCROLL;
                                end
                                else
                                begin
                                    row_next = row_reg + ROW_W'(1);
                                end
                            end
                            else
                            begin
                                col_next = col_reg + COL_W'(1);
                            end
                        end

                        CMD_BACKSPACE:
                        begin
                            echo_valid_next = 1'b1;
                            echo_char_next  = BLANK_CHAR;
                            wr_en           = 1'b1;
                            wr_data         = {text_color_reg, BLANK_CHAR};
                            if (col_reg != '0)
                            begin
                                col_next = col_reg - COL_W'(1);
                                wr_addr  = cur_addr - CELL_AW'(1);
                            end
                            else
                            begin
                                wr_addr = cur_addr;
                            end
                        end

                        CMD_CLEAR:
                        begin
                            col_next        = '0;
                            row_next        = '0;
                            sweep_next      = '0;
                            fill_color_next = text_color_reg;
                            state_next      = ST_FILL;
                        end

                        CMD_SET_POS:
                        begin
                            col_next = (32'(cmd_data.new_column) < COLUMNS)
                                     ? COL_W'(cmd_data.new_column) : LAST_COL;
                            row_next = (32'(cmd_data.new_row) < ROWS)
                                     ? ROW_W'(cmd_data.new_row) : LAST_ROW;
                        end

                        CMD_READ:
                        begin
                            if (32'(cmd_data.cell_index) < CELLS)
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = CELL_AW'(cmd_data.cell_index);
                                state_next = ST_READ;
                            end
                        end

                        default:
                        begin
                        end
                    endcase
                end
            end

            ST_READ:
            begin
                read_data_next = rd_data;
                state_next     = ST_DONE;
            end

            ST_SCROLL:
            begin
                rd_en          = 1'b1;
                copy_pend_next = 1'b1;
                copy_addr_next = sweep_reg;
                if (sweep_reg == LAST_COPY)
                begin
                    sweep_next = FILL_START;
                    state_next = ST_FILL;
                end
                else
                begin
                    sweep_next = sweep_reg + CELL_AW'(1);
                end
            end

            ST_FILL:
            begin
                // The last copy of a scroll owns the write port for one cycle.
                if (!copy_pend_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = sweep_reg;
                    wr_data = {fill_color_reg, BLANK_CHAR};
                    if (sweep_reg == LAST_CELL)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        sweep_next = sweep_reg + CELL_AW'(1);
                    end
                end
            end

            ST_DONE:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end
endmodule

FILE: rtl/text_console_writer_core.sv
// ----------------------------------------------------------------------------
// text_console_writer_core
// Character-cell text console with cursor, scrolling and cell read-back.
// ----------------------------------------------------------------------------
// After reset the block sweeps the whole screen to blank white-on-black cells,
// one cell per cycle, before the first command item is taken. A clear, and a
// put character that runs past the last row and so scrolls the screen, are
// long commands, set by the single write port of the screen memory, which
// every cell passes through once. One item is worked on at a time; a finished
// result waits in an output register, so the next item can be taken before
// the result is collected.
module text_console_writer_core #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic       clk,
    input  logic       rst_n,
    tcw_cmd_if.sink    cmd,
    tcw_rsp_if.source  rsp,
    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data
);
    import tcw_pkg::*;

    localparam int CELLS   = COLUMNS * ROWS;
    localparam int CELL_AW = $clog2(CELLS);

    cmd_t               cmd_data;
    rsp_t               res_data;
    rsp_t               rsp_data_reg;
    logic               rsp_valid_reg;
    logic               res_valid;
    logic               res_ready;
    logic               wr_en;
    logic [CELL_AW-1:0] wr_addr;
    logic [15:0]        wr_data;
    logic               rd_en;
    logic [CELL_AW-1:0] rd_addr;
    logic [15:0]        rd_data;

    always_comb
    begin
        cmd_data.command       = cmd.command;
        cmd_data.char_code     = cmd.char_code;
        cmd_data.use_own_color = cmd.use_own_color;
        cmd_data.own_color     = cmd.own_color;
        cmd_data.new_column    = cmd.new_column;
        cmd_data.new_row       = cmd.new_row;
        cmd_data.cell_index    = cmd.cell_index;
    end

    tcw_ctrl #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd_valid   (cmd.valid),
        .cmd_ready   (cmd.ready),
        .cmd_data    (cmd_data),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res_data    (res_data),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data),
        .rd_en       (rd_en),
        .rd_addr     (rd_addr),
        .rd_data     (rd_data)
    );

    tcw_screen_ram #(
        .DEPTH (CELLS),
        .AW    (CELL_AW)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // The output register is free when empty or when its item leaves now.
    assign res_ready = !rsp_valid_reg || rsp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            rsp_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            rsp_data_reg <= res_data;
        end
    end

    assign rsp.valid           = rsp_valid_reg;
    assign rsp.cursor_position = rsp_data_reg.cursor_position;
    assign rsp.cursor_column   = rsp_data_reg.cursor_column;
    assign rsp.cursor_row      = rsp_data_reg.cursor_row;
    assign rsp.echo_valid      = rsp_data_reg.echo_valid;
    assign rsp.echo_char       = rsp_data_reg.echo_char;
    assign rsp.read_data       = rsp_data_reg.read_data;
endmodule

FILE: rtl/tcw_checker.sv
// ----------------------------------------------------------------------------
// tcw_checker
// Port-level checks for the text console writer, bound to its top level.
// ----------------------------------------------------------------------------
module tcw_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        cmd_valid,
    input logic        cmd_ready,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic [10:0] cursor_position,
    input logic [6:0]  cursor_column,
    input logic [4:0]  cursor_row,
    input logic        echo_valid,
    input logic [7:0]  echo_char,
    input logic [15:0] read_data
);
    // A result that is not taken stays on the port unchanged.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(cursor_position)
            && $stable(cursor_column) && $stable(cursor_row)
            && $stable(echo_valid) && $stable(echo_char) && $stable(read_data))
        else $error("result changed while stalled");

    // Only one command is in work at a time.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready |=> !cmd_ready)
        else $error("command taken while busy");

    a_echo_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !echo_valid |-> echo_char == 8'h00)
        else $error("echo byte without echo");

    // Commands that echo never return cell data.
    a_echo_no_read: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && echo_valid |-> read_data == 16'h0000)
        else $error("cell data on an echoing command");
endmodule

bind text_console_writer_core tcw_checker u_tcw_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd_valid       (cmd.valid),
    .cmd_ready       (cmd.ready),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .cursor_position (rsp.cursor_position),
    .cursor_column   (rsp.cursor_column),
    .cursor_row      (rsp.cursor_row),
    .echo_valid      (rsp.echo_valid),
    .echo_char       (rsp.echo_char),
    .read_data       (rsp.read_data)
);
